// ----- hdl/kss_pkg.sv -----
`timescale 1ns / 1ps
// kss_pkg: shared constants, sequencer states and store port struct for the
// k-th smallest selector. No dependencies.
package kss_pkg;

   // store size and derived widths
   localparam int MAX_ELEMENTS = 1024;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
   localparam int VALUE_W      = 32;
   localparam int RANK_W       = 11;

   // sequencer states
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CHECK,
      ST_PIVOT,
      ST_CMP,
      ST_SWAP1,
      ST_SWAP2,
      ST_FINAL,
      ST_FIN1,
      ST_FIN2,
      ST_RESRD,
      ST_OUT
   } state_type;

   // one write and one read access to the element store
   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   waddr;
      logic [VALUE_W-1:0] wdata;
      logic               re;
      logic [IDX_W-1:0]   raddr;
   } mem_req_type;

endpackage

// ----- hdl/kss_store.sv -----
`timescale 1ns / 1ps
// kss_store: element store, one write port and one registered read port.
// Depends on kss_pkg.
module kss_store (
   input  logic                         clock,
   input  kss_pkg::mem_req_type         mem_req,
   output logic [kss_pkg::VALUE_W-1:0]  rd_data
);

   logic [kss_pkg::VALUE_W-1:0] mem [kss_pkg::MAX_ELEMENTS];
   logic [kss_pkg::VALUE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // read port, data registered
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_data_ff <= mem[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/kth_smallest_select.sv -----
`timescale 1ns / 1ps
// kth_smallest_select: collects signed values into a store and returns the
// k-th smallest by in-place quickselect. Depends on kss_pkg and kss_store.
//
// Elements are loaded at one per cycle while req_tready is high; the transfer
// with req_tlast set is the final element and carries the wanted rank
// (1 = smallest) in req_tdata. The block then drops req_tready and partitions
// the active range around its last element (Lomuto scheme), narrowing the
// range until the rank is found. Each pass reads the pivot, compares each
// element against it, swaps each element below the pivot that is out of place
// with two writes and then places the pivot with one read and two writes; the
// store's one read and one write per cycle shapes these steps. Sorted input is
// the slowest case. A rank of 0 or above the element count returns value 0
// with rsp_tuser set, in the cycle after the last transfer. Elements beyond
// the store size are dropped. The result is held until taken.
module kth_smallest_select (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [31:0] value, [42:32] rank, [47:43] zero
   input  logic        req_tlast,   // last_item
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] selected_value
   output logic [0:0]  rsp_tuser    // [0] rank_error
);

   localparam int IDX_W   = kss_pkg::IDX_W;
   localparam int CNT_W   = kss_pkg::CNT_W;
   localparam int VALUE_W = kss_pkg::VALUE_W;

   kss_pkg::state_type   state_ff, state_in;
   kss_pkg::mem_req_type mem_req;
   logic [VALUE_W-1:0]   rd_data;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   lo_ff, lo_in;
   logic [IDX_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [IDX_W-1:0]   next_ff, next_in;
   logic [VALUE_W-1:0] pivot_ff, pivot_in;
   logic [VALUE_W-1:0] hold_ff, hold_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_err_ff, rsp_err_in;

   logic               req_xfer;
   logic               rsp_xfer;
   logic [VALUE_W-1:0] in_value;
   logic [10:0]        in_rank;
   logic [CNT_W-1:0]   new_count;
   logic               bad_rank;
   logic               is_less;
   logic [IDX_W-1:0]   j_inc;
   logic               j_more;
   logic [CNT_W-1:0]   part_k;

   kss_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // handshake and field decode
   assign req_tready = (state_ff == kss_pkg::ST_LOAD);
   assign rsp_tvalid = (state_ff == kss_pkg::ST_OUT);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign in_value   = req_tdata[31:0];
   assign in_rank    = req_tdata[42:32];
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_err_ff;

   // shared compare and index arithmetic
   assign new_count = count_ff +
                      CNT_W'(count_ff < CNT_W'(kss_pkg::MAX_ELEMENTS));
   assign bad_rank  = (in_rank == 11'd0) || (32'(in_rank) > 32'(new_count));
   assign is_less   = $signed(rd_data) < $signed(pivot_ff);
   assign j_inc     = j_ff + IDX_W'(1);
   assign j_more    = (j_inc != hi_ff);
   assign part_k    = CNT_W'(next_ff) - CNT_W'(lo_ff) + CNT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kss_pkg::ST_LOAD: begin
            if (req_xfer && req_tlast) begin
               state_in = bad_rank ? kss_pkg::ST_OUT : kss_pkg::ST_CHECK;
            end
         end
         kss_pkg::ST_CHECK: begin
            state_in = (lo_ff >= hi_ff) ? kss_pkg::ST_RESRD : kss_pkg::ST_PIVOT;
         end
         kss_pkg::ST_PIVOT: state_in = kss_pkg::ST_CMP;
         kss_pkg::ST_CMP: begin
            if (is_less && (j_ff != next_ff)) begin
               state_in = kss_pkg::ST_SWAP1;
            end else if (!j_more) begin
               state_in = kss_pkg::ST_FINAL;
            end
         end
         kss_pkg::ST_SWAP1: state_in = kss_pkg::ST_SWAP2;
         kss_pkg::ST_SWAP2: begin
            state_in = j_more ? kss_pkg::ST_CMP : kss_pkg::ST_FINAL;
         end
         kss_pkg::ST_FINAL: state_in = kss_pkg::ST_FIN1;
         kss_pkg::ST_FIN1:  state_in = kss_pkg::ST_FIN2;
         kss_pkg::ST_FIN2: begin
            if ((rem_ff == part_k) || ((rem_ff < part_k) && (next_ff == lo_ff))) begin
               state_in = kss_pkg::ST_OUT;
            end else begin
               state_in = kss_pkg::ST_CHECK;
            end
         end
         kss_pkg::ST_RESRD: state_in = kss_pkg::ST_OUT;
         kss_pkg::ST_OUT: begin
            if (rsp_xfer) begin
               state_in = kss_pkg::ST_LOAD;
            end
         end
         default: state_in = kss_pkg::ST_LOAD;
      endcase
   end

   // datapath and store accesses
   always_comb begin
      mem_req      = '0;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rem_in       = rem_ff;
      j_in         = j_ff;
      next_in      = next_ff;
      pivot_in     = pivot_ff;
      hold_in      = hold_ff;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      case (state_ff)
         kss_pkg::ST_LOAD: begin
            if (req_xfer) begin
               mem_req.we    = (count_ff < CNT_W'(kss_pkg::MAX_ELEMENTS));
               mem_req.waddr = count_ff[IDX_W-1:0];
               mem_req.wdata = in_value;
               count_in      = new_count;
               if (req_tlast) begin
                  count_in     = '0;
                  lo_in        = '0;
                  hi_in        = IDX_W'(new_count - CNT_W'(1));
                  rem_in       = CNT_W'(in_rank);
                  rsp_value_in = '0;
                  rsp_err_in   = bad_rank;
               end
            end
         end
         // single element left, or fetch the pivot
         kss_pkg::ST_CHECK: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = (lo_ff >= hi_ff) ? lo_ff : hi_ff;
            j_in          = lo_ff;
            next_in       = lo_ff;
         end
         kss_pkg::ST_PIVOT: begin
            pivot_in      = rd_data;
            mem_req.re    = 1'b1;
            mem_req.raddr = j_ff;
         end
         // compare element j against the pivot
         kss_pkg::ST_CMP: begin
            if (is_less && (j_ff != next_ff)) begin
               hold_in       = rd_data;
               mem_req.re    = 1'b1;
               mem_req.raddr = next_ff;
            end else begin
               if (is_less) begin
                  next_in = next_ff + IDX_W'(1);
               end
               j_in          = j_inc;
               mem_req.re    = j_more;
               mem_req.raddr = j_inc;
            end
         end
         // swap: store[j] takes store[next]
         kss_pkg::ST_SWAP1: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = j_ff;
            mem_req.wdata = rd_data;
         end
         // swap: store[next] takes old store[j], then move on
         kss_pkg::ST_SWAP2: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = next_ff;
            mem_req.wdata = hold_ff;
            next_in       = next_ff + IDX_W'(1);
            j_in          = j_inc;
            mem_req.re    = j_more;
            mem_req.raddr = j_inc;
         end
         // place the pivot at its final slot
         kss_pkg::ST_FINAL: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = next_ff;
         end
         kss_pkg::ST_FIN1: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = hi_ff;
            mem_req.wdata = rd_data;
         end
         // narrow the range toward the wanted rank
         kss_pkg::ST_FIN2: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = next_ff;
            mem_req.wdata = pivot_ff;
            rsp_value_in  = pivot_ff;
            if (rem_ff < part_k) begin
               if (next_ff != lo_ff) begin
                  hi_in = next_ff - IDX_W'(1);
               end
            end else if (rem_ff != part_k) begin
               rem_in = rem_ff - part_k;
               lo_in  = next_ff + IDX_W'(1);
            end
         end
         kss_pkg::ST_RESRD: rsp_value_in = rd_data;
         kss_pkg::ST_OUT: ;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kss_pkg::ST_LOAD;
         count_ff <= '0;
         lo_ff    <= '0;
         hi_ff    <= '0;
         rem_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         rem_ff   <= rem_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      j_ff         <= j_in;
      next_ff      <= next_in;
      pivot_ff     <= pivot_in;
      hold_ff      <= hold_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // element count never passes the store size
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(kss_pkg::MAX_ELEMENTS))
      else $error("element count above store size");

   // scan index stays below the pivot slot and at or above the fill point
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == kss_pkg::ST_CMP) |-> ((j_ff < hi_ff) && (next_ff <= j_ff)))
      else $error("partition indexes out of order");

   // an error result carries value zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_err_ff) |-> (rsp_value_ff == '0))
      else $error("error result with nonzero value");

   // a last transfer clears the count
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tlast) |=> (count_ff == '0))
      else $error("count not cleared after last transfer");

endmodule

// ----- test/kth_smallest_select_tb.sv -----
`timescale 1ns / 1ps
// kth_smallest_select_tb: self-checking bench for the k-th smallest selector.
// Streams value sets with random gaps and back-pressure and checks every result
// against an in-bench quickselect. Depends on kss_pkg and kth_smallest_select.
module kth_smallest_select_tb;

   localparam int  MAX_ELEMENTS   = kss_pkg::MAX_ELEMENTS;
   localparam int  VALUE_W        = kss_pkg::VALUE_W;
   localparam int  RANK_W         = kss_pkg::RANK_W;
   localparam int  WATCHDOG_LIMIT = 200000;
   localparam int  DRAIN_CYCLES   = 60;
   localparam int  TARGET_ITEMS   = 450;
   localparam logic signed [VALUE_W-1:0] MIN_V = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] MAX_V = 32'sh7FFF_FFFF;

   typedef enum int {FILL_RANDOM, FILL_NARROW, FILL_EXTREME, FILL_RISING, FILL_FALLING}
      fill_kind_type;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic [RANK_W-1:0]         rank;
      logic                      last_item;
   } element_item_type;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      rank_error;
   } selection_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // [31:0] value, [42:32] rank, [47:43] zero
   logic        req_tlast;   // last_item
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] selected_value
   logic [0:0]  rsp_tuser;   // [0] rank_error

   element_item_type          pending_items[$];
   logic signed [VALUE_W-1:0] set_values[$];
   selection_result_type      expected_results[$];

   int error_count    = 0;
   int accepted_items = 0;
   int quiet_from     = 0;
   int send_gap       = 0;
   int take_stall     = 0;
   int idle_cycles    = 0;

   kth_smallest_select uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // rank-th smallest by lomuto quickselect with the last element as pivot
   function automatic logic signed [VALUE_W-1:0] kth_of_set(
         input logic signed [VALUE_W-1:0] vals[$], input int want);
      int lo, hi, nxt, q, k, j;
      logic signed [VALUE_W-1:0] pivot, tmp;
      lo = 0;
      hi = vals.size() - 1;
      while (1) begin
         if (lo >= hi) return vals[lo];
         pivot = vals[hi];
         nxt = lo;
         for (j = lo; j < hi; j++) begin
            if (vals[j] < pivot) begin
               tmp = vals[j];
               vals[j] = vals[nxt];
               vals[nxt] = tmp;
               nxt++;
            end
         end
         tmp = vals[hi];
         vals[hi] = vals[nxt];
         vals[nxt] = tmp;
         q = nxt;
         k = q - lo + 1;
         if (want == k) return vals[q];
         if (want < k) begin
            if (q == lo) return vals[q];
            hi = q - 1;
         end else begin
            want -= k;
            lo = q + 1;
         end
      end
   endfunction

   // store one accepted element; a last element closes the set
   task automatic store_element(input element_item_type it);
      selection_result_type res;
      if (set_values.size() < MAX_ELEMENTS) set_values.push_back(it.value);
      if (it.last_item) begin
         if (it.rank == 0 || it.rank > set_values.size()) begin
            res.value = '0;
            res.rank_error = 1'b1;
         end else begin
            res.value = kth_of_set(set_values, int'(it.rank));
            res.rank_error = 1'b0;
         end
         expected_results.push_back(res);
         set_values.delete();
      end
   endtask

   // queue a whole set; the rank rides on the last element, others get noise
   task automatic queue_set(input logic signed [VALUE_W-1:0] vals[$], input int rank_v);
      element_item_type it;
      for (int i = 0; i < vals.size(); i++) begin
         it.value = vals[i];
         it.last_item = (i == vals.size() - 1);
         it.rank = it.last_item ? RANK_W'(rank_v) : RANK_W'($urandom_range(0, 2047));
         pending_items.push_back(it);
      end
   endtask

   // request driver: bursts of idle cycles, valid held until the transfer
   always @(posedge clock) begin
      element_item_type it;
      logic             show;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            store_element(pending_items.pop_front());
            accepted_items++;
         end
         show = 1'b0;
         if (req_tvalid && !req_tready) begin
            show = 1'b1;
         end else if (accepted_items >= quiet_from) begin
            show = (pending_items.size() > 0);
         end else if (send_gap > 0) begin
            send_gap--;
         end else if ($urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 8) - 1;
         end else begin
            show = (pending_items.size() > 0);
         end
         req_tvalid <= show;
         if (show) begin
            it = pending_items[0];
            req_tdata <= {5'b0, it.rank, it.value};
            req_tlast <= it.last_item;
         end
      end
   end

   // result monitor with random back-pressure, plus the no-progress counter
   always @(posedge clock) begin
      selection_result_type exp_r;
      if (reset) begin
         rsp_tready  <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result value %0d error %0b", $time,
                        $signed(rsp_tdata), rsp_tuser[0]);
               error_count++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_tdata !== exp_r.value) begin
                  $display("%0t: selected_value expected %0d actual %0d", $time,
                           exp_r.value, $signed(rsp_tdata));
                  error_count++;
               end
               if (rsp_tuser[0] !== exp_r.rank_error) begin
                  $display("%0t: rank_error expected %0b actual %0b", $time,
                           exp_r.rank_error, rsp_tuser[0]);
                  error_count++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (accepted_items >= quiet_from) begin
            rsp_tready <= 1'b1;
         end else if (take_stall > 0) begin
            take_stall--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 7) == 0) begin
            take_stall = $urandom_range(1, 8) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      logic signed [VALUE_W-1:0] vals[$];
      fill_kind_type kind;
      int n, pick, rank_v, base, step;
      reset = 1'b1;
      quiet_from = 1 << 30;

      // directed: extremes, bad ranks, duplicates, sorted input
      vals = '{MIN_V};
      queue_set(vals, 1);
      vals = '{MAX_V};
      queue_set(vals, 2);
      vals = '{MAX_V, MIN_V, -32'sd1, 32'sd0, 32'sd1};
      queue_set(vals, 3);
      vals = '{32'sd7, -32'sd7, 32'sd3};
      queue_set(vals, 0);
      vals = '{32'sd5, 32'sd5, 32'sd5, 32'sd5};
      queue_set(vals, 4);
      vals = '{-32'sd3, -32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2};
      queue_set(vals, 6);
      vals = '{MAX_V, MIN_V};
      queue_set(vals, 2047);

      // random sets
      while (pending_items.size() < TARGET_ITEMS) begin
         vals.delete();
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
         kind = fill_kind_type'($urandom_range(0, 4));
         base = $urandom_range(0, 2000) - 1000;
         step = $urandom_range(0, 3);
         for (int i = 0; i < n; i++) begin
            case (kind)
               FILL_RANDOM:  vals.push_back($urandom);
               FILL_NARROW:  vals.push_back($urandom_range(0, 16) - 8);
               FILL_EXTREME: begin
                  pick = $urandom_range(0, 3);
                  vals.push_back(pick == 0 ? MIN_V : pick == 1 ? MAX_V :
                                 pick == 2 ? 32'sd0 : -32'sd1);
               end
               FILL_RISING:  vals.push_back(base + i * step);
               default:      vals.push_back(base - i * step);
            endcase
         end
         pick = $urandom_range(0, 9);
         if (pick < 8) rank_v = $urandom_range(1, n);
         else if (pick == 8) rank_v = $urandom_range(0, 1) ? 0 : n + 1;
         else rank_v = $urandom_range(0, 2047);
         queue_set(vals, rank_v);
      end
      quiet_from = pending_items.size() - pending_items.size() / 6;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // wait for all transfers, guarded by the watchdog
      while (!(pending_items.size() == 0 && expected_results.size() == 0)
             && idle_cycles < WATCHDOG_LIMIT)
         @(negedge clock);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
      end else begin
         repeat (DRAIN_CYCLES) @(negedge clock);
         if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb: success");
         end else begin
            $display("tb: failure");
         end
      end
      $finish;
   end

endmodule
